FILE: rtl/core/counting_semaphore_priority_queue_macros.svh
// Assertion macros for the counting semaphore block.
// Used by the top level only; no other dependencies.
`ifndef COUNTING_SEMAPHORE_PRIORITY_QUEUE_MACROS_SVH
`define COUNTING_SEMAPHORE_PRIORITY_QUEUE_MACROS_SVH
// implication checked on every edge outside reset
`define CSPQ_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
// next-cycle implication
`define CSPQ_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
`endif

FILE: rtl/core/csq_pkg.sv
// Shared types and constants for the counting semaphore block.
// No dependencies.
`default_nettype none
package csq_pkg;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TASK_BITS_DEF   = 8;
  localparam int PRIO_BITS_DEF   = 8;
  localparam int COUNT_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    K_WAIT = 2'd0, K_TRY = 2'd1, K_SIGNAL = 2'd2, K_CANCEL = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0, ST_BUSY = 3'd1, ST_QUEUED = 3'd2, ST_FULL = 3'd3,
    ST_SIGNALLED = 3'd4, ST_CANCELLED = 3'd5, ST_MISS = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    B_IDLE, B_DECIDE, B_SCAN, B_SHIFT, B_DONE
  } bstate_t;

  localparam logic [0:0] ADDR_INIT = 1'b0;
  localparam logic [0:0] ADDR_MAX  = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/core/counting_semaphore_priority_queue.sv
// Top level of the counting semaphore with priority wait queue.
// Depends on csq_pkg, csq_front, csq_back and the macros header.
//
// Use: request words enter on s_axis (kind, task, priority); one result
// word per request leaves on m_axis. Registers via APB: start count at
// 0x0 (a write reloads the count and empties the queue), count limit at
// 0x4 (0 = no limit).
// A two-word request queue lets the sender run ahead of the back part.
// A queued wait, a cancel or a signal that wakes a waiter walks the queue
// one entry a cycle; grant, busy, full, overflow and an empty-queue signal
// need no walk. One request is worked at a time: the back part takes no
// new request until the result of the last one has been accepted.
// Reset: count 0, limit none, queue empty, no result pending.
// A stalled receiver holds the result word; the back part waits in turn
// and the request queue fills, then s_axis_tready drops.
`default_nettype none
`include "counting_semaphore_priority_queue_macros.svh"
module counting_semaphore_priority_queue import csq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TASK_BITS   = TASK_BITS_DEF,
  parameter int PRIO_BITS   = PRIO_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic s_axis_tvalid,
  output logic       s_axis_tready,
  // task_id, priority_req (low to high)
  input  wire  logic [TASK_BITS+PRIO_BITS-1:0] s_axis_tdata,
  // kind
  input  wire  logic [1:0] s_axis_tuser,
  output logic       m_axis_tvalid,
  input  wire  logic m_axis_tready,
  // status, overflow, wake_valid, wake_task, count_now, waiters_now (low to high),
  // zero fill up to whole bytes
  output logic [((5+TASK_BITS+COUNT_BITS+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
  input  wire  logic psel,
  input  wire  logic penable,
  input  wire  logic pwrite,
  input  wire  logic [2:0] paddr,
  input  wire  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = 5 + TASK_BITS + COUNT_BITS + NW;
  localparam int OW = ((RW + 7) / 8) * 8;
  logic [COUNT_BITS-1:0] init_reg, max_reg;
  logic wr_en, reload;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign reload = wr_en && (paddr[2] == ADDR_INIT);
  always_ff @(posedge clk) begin
    if (rst) begin
      init_reg <= '0; max_reg <= '0;
    end else if (wr_en) begin
      if (paddr[2] == ADDR_INIT) init_reg <= pwdata[COUNT_BITS-1:0];
      else max_reg <= pwdata[COUNT_BITS-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[2] == ADDR_INIT) prdata[COUNT_BITS-1:0] = init_reg;
    else prdata[COUNT_BITS-1:0] = max_reg;
  end

  logic q_valid, q_take, busy;
  logic [TASK_BITS+PRIO_BITS+1:0] q_word;
  csq_front #(.TASK_BITS(TASK_BITS), .PRIO_BITS(PRIO_BITS)) u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_word({s_axis_tdata, s_axis_tuser}), .q_valid, .q_take, .q_word);

  status_t r_status;
  logic r_ovf, r_wv;
  logic [TASK_BITS-1:0] r_wt;
  logic [COUNT_BITS-1:0] r_count, r_init;
  logic [NW-1:0] r_waiters;
  // on reset the count loads the (reset) register value
  assign r_init = reload ? pwdata[COUNT_BITS-1:0] : init_reg;
  csq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .TASK_BITS(TASK_BITS),
             .PRIO_BITS(PRIO_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst, .reload, .init_val(rst ? '0 : r_init), .max_val(max_reg),
    .q_valid, .q_take, .q_word, .r_valid(m_axis_tvalid), .r_ready(m_axis_tready),
    .r_status, .r_ovf, .r_wv, .r_wt, .r_count, .r_waiters, .busy);
  assign m_axis_tdata = OW'({r_waiters, r_count, r_wt, r_wv, r_ovf, r_status});

  `CSPQ_ASSERT_IMP(a_ovf_status, m_axis_tvalid && r_ovf, r_status == ST_MISS)
  `CSPQ_ASSERT_IMP(a_wake_sig, m_axis_tvalid && r_wv, r_status == ST_SIGNALLED)
  `CSPQ_ASSERT_IMP(a_waiters_max, 1'b1, r_waiters <= NW'(QUEUE_DEPTH))
  `CSPQ_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready && !reload, m_axis_tvalid)
  `CSPQ_ASSERT_IMP(a_idle_quiet, !busy, !m_axis_tvalid)
endmodule
`default_nettype wire

FILE: rtl/core/csq_front.sv
// Front part: accepts input words and holds them in a two-entry queue.
// Depends on csq_pkg.
`default_nettype none
module csq_front import csq_pkg::*; #(
  parameter int TASK_BITS = TASK_BITS_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic in_valid,
  output logic       in_ready,
  input  wire  logic [TASK_BITS+PRIO_BITS+1:0] in_word,
  output logic       q_valid,
  input  wire  logic q_take,
  output logic [TASK_BITS+PRIO_BITS+1:0] q_word
);
  localparam int W = TASK_BITS + PRIO_BITS + 2;
  logic [W-1:0] mem [2];
  logic rd, wr;
  logic [1:0] fill;
  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_word   = mem[rd];
  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 1'b0; wr <= 1'b0; fill <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr <= ~wr;
      if (q_take && q_valid) rd <= ~rd;
      fill <= fill + 2'(in_valid && in_ready) - 2'(q_take && q_valid);
    end
  end
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wr] <= in_word;
  end
endmodule
`default_nettype wire

FILE: rtl/core/csq_back.sv
// Back part: semaphore count and sorted wait queue, one entry step per cycle.
// Depends on csq_pkg.
`default_nettype none
module csq_back import csq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TASK_BITS   = TASK_BITS_DEF,
  parameter int PRIO_BITS   = PRIO_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic reload,
  input  wire  logic [COUNT_BITS-1:0] init_val,
  input  wire  logic [COUNT_BITS-1:0] max_val,
  input  wire  logic q_valid,
  output logic       q_take,
  input  wire  logic [TASK_BITS+PRIO_BITS+1:0] q_word,
  output logic       r_valid,
  input  wire  logic r_ready,
  output status_t    r_status,
  output logic       r_ovf,
  output logic       r_wv,
  output logic [TASK_BITS-1:0] r_wt,
  output logic [COUNT_BITS-1:0] r_count,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] r_waiters,
  output logic       busy
);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  logic [TASK_BITS-1:0] qt [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] qp [QUEUE_DEPTH];
  logic [COUNT_BITS-1:0] cnt;
  logic [NW-1:0] total;
  bstate_t st, st_next;
  kind_t kind;
  logic [TASK_BITS-1:0] tid;
  logic [PRIO_BITS-1:0] pri;
  logic [NW-1:0] pos;       // scan / shift index
  logic ins;                // 1 insert, 0 remove
  status_t status;
  logic ovf, wv;
  logic [TASK_BITS-1:0] wt;
  logic [COUNT_BITS-1:0] lim;
  assign lim = (max_val == '0) ? '1 : max_val;
  logic [IW-1:0] pi;
  assign pi = pos[IW-1:0];

  // next state
  always_comb begin
    st_next = st;
    case (st)
      B_IDLE:   if (q_valid) st_next = B_DECIDE;
      B_DECIDE: begin
        st_next = B_DONE;
        if ((kind == K_WAIT) && cnt == '0 && total < NW'(QUEUE_DEPTH)) st_next = B_SCAN;
        if (kind == K_CANCEL) st_next = B_SCAN;
        if (kind == K_SIGNAL && cnt < lim && total != '0) st_next = B_SHIFT;
      end
      B_SCAN: begin
        if (pos >= total) st_next = ins ? B_SHIFT : B_DONE;
        else if (ins ? (qp[pi] < pri) : (qt[pi] == tid)) st_next = B_SHIFT;
      end
      B_SHIFT: begin
        // insert ends at the head or once the slot above holds an equal or higher priority
        if (ins ? !(pos != '0 && (qp[IW'(pos - 1'b1)] < pri))
                : (NW'(pos + 1'b1) >= total)) st_next = B_DONE;
      end
      B_DONE:   if (r_ready) st_next = B_IDLE;
      default:  st_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_take    = (st == B_IDLE) && q_valid;
    r_valid   = (st == B_DONE);
    busy      = (st != B_IDLE);
    r_status  = status;
    r_ovf     = ovf;
    r_wv      = wv;
    r_wt      = wt;
    r_count   = cnt;
    r_waiters = total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= B_IDLE; cnt <= init_val; total <= '0;
    end else if (reload) begin
      cnt <= init_val; total <= '0;
    end else begin
      st <= st_next;
      case (st)
        B_IDLE: if (q_valid) begin
          kind <= kind_t'(q_word[1:0]);
          tid  <= q_word[TASK_BITS+1:2];
          pri  <= q_word[TASK_BITS+PRIO_BITS+1:TASK_BITS+2];
        end
        B_DECIDE: begin
          ovf <= 1'b0; wv <= 1'b0; wt <= '0; pos <= '0;
          status <= ST_MISS;
          case (kind)
            K_WAIT, K_TRY: begin
              if (cnt != '0) begin
                cnt <= cnt - 1'b1; status <= ST_GRANTED;
              end else if (kind == K_TRY) status <= ST_BUSY;
              else if (total >= NW'(QUEUE_DEPTH)) ovf <= 1'b1;
              else begin
                status <= ST_QUEUED; ins <= 1'b1;
              end
            end
            K_SIGNAL: begin
              if (cnt >= lim) status <= ST_FULL;
              else begin
                status <= ST_SIGNALLED;
                if (total != '0) begin
                  wv <= 1'b1; wt <= qt[0]; ins <= 1'b0;
                end else cnt <= cnt + 1'b1;
              end
            end
            default: ins <= 1'b0;
          endcase
        end
        B_SCAN: begin
          if (pos >= total) begin
            if (ins) pos <= total;
          end else if (ins ? (qp[pi] < pri) : (qt[pi] == tid)) begin
            if (ins) pos <= total;
            else status <= ST_CANCELLED;
            tid <= ins ? tid : tid;
          end else pos <= pos + 1'b1;
        end
        B_SHIFT: begin
          if (ins) begin
            // walk down from the tail to the insert slot
            if (pos != '0 && (qp[IW'(pos - 1'b1)] < pri)) begin
              qt[pi] <= qt[IW'(pos - 1'b1)];
              qp[pi] <= qp[IW'(pos - 1'b1)];
              pos <= pos - 1'b1;
            end else begin
              qt[pi] <= tid; qp[pi] <= pri;
              total <= total + 1'b1;
              pos <= total;
            end
          end else begin
            if (NW'(pos + 1'b1) >= total) total <= total - 1'b1;
            else begin
              qt[pi] <= qt[IW'(pos + 1'b1)];
              qp[pi] <= qp[IW'(pos + 1'b1)];
              pos <= pos + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
